FILE: src/gepc_pkg.sv
// Shared constants, control structs and width helpers for the grid exit path counter.
package gepc_pkg;

   localparam int DEF_MAX_ROWS  = 64;
   localparam int DEF_MAX_COLS  = 64;
   localparam int DEF_MAX_MOVES = 64;

   localparam int COUNT_W = 30;
   localparam int CFG_W   = 7;
   localparam int POS_W   = 6;
   localparam int MOVE_W  = 7;
   localparam int CSR_IDX_W = 1;

   localparam logic [COUNT_W-1:0] PATH_MOD = 30'd1000000007;

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_ROWS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_COLS = 1'd1;

   // Neighbor order of one cell: up, right, down, left.
   localparam logic [1:0] PH_UP    = 2'd0;
   localparam logic [1:0] PH_RIGHT = 2'd1;
   localparam logic [1:0] PH_DOWN  = 2'd2;
   localparam logic [1:0] PH_LEFT  = 2'd3;

   // Control that travels with one neighbor read to the accumulator.
   typedef struct packed {
      logic valid;
      logic in_grid;
      logic zero_src;
      logic first;
      logic last;
      logic rbank;
      logic wbank;
   } issue_type;

   // Bits needed to index n entries.
   function automatic int idx_w(input int n);
      return (n > 1) ? $clog2(n) : 1;
   endfunction

   // Bits needed to hold the values 0 to n.
   function automatic int cnt_w(input int n);
      return $clog2(n + 1);
   endfunction

endpackage

FILE: src/grid_exit_path_counter_core.sv
// A start outside the grid or a zero move limit skips the sweep and goes straight to the result.
// Otherwise the walker steps each cell through four neighbor phases on the one read port
// of the previous layer store, and each layer ends with an idle gap state.
// Throughput: one query at a time; the next is taken once the result sits in the output register.
// Reset sets both grid sizes to 1 and idles the block; the layer stores need no clearing pass,
// since the first layer of each query treats every stored neighbor as zero.
module grid_exit_path_counter_core
   import gepc_pkg::*;
#(
   parameter int MAX_ROWS  = DEF_MAX_ROWS,
   parameter int MAX_COLS  = DEF_MAX_COLS,
   parameter int MAX_MOVES = DEF_MAX_MOVES
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [POS_W-1:0]     req_start_row,
   input  logic [POS_W-1:0]     req_start_col,
   input  logic [MOVE_W-1:0]    req_move_limit,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [COUNT_W-1:0]   rsp_path_count,
   output logic                 rsp_bad_start,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   localparam int DEPTH = MAX_ROWS * MAX_COLS;
   localparam int AW    = idx_w(DEPTH);
   localparam int RCW   = cnt_w(MAX_ROWS);
   localparam int CCW   = cnt_w(MAX_COLS);
   localparam int MCW   = cnt_w(MAX_MOVES);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_RUN   = 3'd1;
   localparam logic [2:0] ST_FETCH = 3'd2;
   localparam logic [2:0] ST_LOAD  = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [CFG_W-1:0]   grid_rows_ff, grid_rows_in;
   logic [CFG_W-1:0]   grid_cols_ff, grid_cols_in;
   logic [2:0]         state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0] rsp_path_count_ff, rsp_path_count_in;
   logic               rsp_bad_start_ff, rsp_bad_start_in;
   logic [COUNT_W-1:0] res_count_ff, res_count_in;
   logic               res_bad_ff, res_bad_in;
   logic [AW-1:0]      start_addr_ff, start_addr_in;
   logic [MCW-1:0]     moves_ff, moves_in;

   logic [RCW-1:0]     rows_lim;
   logic [CCW-1:0]     cols_lim;
   logic [MCW-1:0]     moves_lim;
   logic               req_fire;
   logic               start_bad;
   logic               walk_start;
   logic               rsp_free;
   logic               fetch;

   logic               walk_busy;
   logic               walk_done;
   logic               walk_rd_en;
   logic               walk_rd_bank;
   logic [AW-1:0]      walk_rd_addr;
   issue_type          walk_iss;
   logic [AW-1:0]      walk_cell;

   logic               wr_en;
   logic               wr_bank;
   logic [AW-1:0]      wr_addr;
   logic [COUNT_W-1:0] wr_data;

   logic               rd_en0, rd_en1;
   logic               wr_en0, wr_en1;
   logic [AW-1:0]      rd_addr;
   logic [COUNT_W-1:0] rd_data0, rd_data1;

   assign rows_lim  = (32'(grid_rows_ff) > 32'(MAX_ROWS)) ? RCW'(MAX_ROWS) : RCW'(grid_rows_ff);
   assign cols_lim  = (32'(grid_cols_ff) > 32'(MAX_COLS)) ? CCW'(MAX_COLS) : CCW'(grid_cols_ff);
   assign moves_lim = (32'(req_move_limit) > 32'(MAX_MOVES)) ? MCW'(MAX_MOVES)
                                                             : MCW'(req_move_limit);

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign start_bad  = (32'(req_start_row) >= 32'(rows_lim)) ||
                       (32'(req_start_col) >= 32'(cols_lim));
   assign walk_start = req_fire && !start_bad && (moves_lim != '0);
   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign fetch      = (state_ff == ST_FETCH);

   assign start_addr_in = AW'(32'(req_start_row) * 32'(MAX_COLS) + 32'(req_start_col));

   always_comb begin
      grid_rows_in = grid_rows_ff;
      grid_cols_in = grid_cols_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_GRID_ROWS: grid_rows_in = csr_wdata;
            CSR_GRID_COLS: grid_cols_in = csr_wdata;
            default: begin
               grid_rows_in = grid_rows_ff;
               grid_cols_in = grid_cols_ff;
            end
         endcase
      end
   end

   always_comb begin
      state_in          = state_ff;
      res_count_in      = res_count_ff;
      res_bad_in        = res_bad_ff;
      moves_in          = moves_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      rsp_path_count_in = rsp_path_count_ff;
      rsp_bad_start_in  = rsp_bad_start_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               res_count_in = '0;
               res_bad_in   = start_bad;
               moves_in     = moves_lim;
               state_in     = walk_start ? ST_RUN : ST_DONE;
            end
         end
         ST_RUN: begin
            if (walk_done) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            // The last layer was written to the bank given by the parity of the move count.
            res_count_in = moves_ff[0] ? rd_data1 : rd_data0;
            state_in     = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in      = 1'b1;
               rsp_path_count_in = res_count_ff;
               rsp_bad_start_in  = res_bad_ff;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_rows_ff <= CFG_W'(1);
         grid_cols_ff <= CFG_W'(1);
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         grid_rows_ff <= grid_rows_in;
         grid_cols_ff <= grid_cols_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_path_count_ff <= rsp_path_count_in;
      rsp_bad_start_ff  <= rsp_bad_start_in;
      res_count_ff      <= res_count_in;
      res_bad_ff        <= res_bad_in;
      moves_ff          <= moves_in;
      if (req_fire) begin
         start_addr_ff <= start_addr_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_path_count = rsp_path_count_ff;
   assign rsp_bad_start  = rsp_bad_start_ff;

   gepc_cell_walker #(
      .MAX_ROWS  (MAX_ROWS),
      .MAX_COLS  (MAX_COLS),
      .MAX_MOVES (MAX_MOVES)
   ) u_walker (
      .clock     (clock),
      .reset     (reset),
      .start     (walk_start),
      .rows      (rows_lim),
      .cols      (cols_lim),
      .moves     (moves_ff),
      .busy      (walk_busy),
      .done      (walk_done),
      .rd_en     (walk_rd_en),
      .rd_bank   (walk_rd_bank),
      .rd_addr   (walk_rd_addr),
      .iss       (walk_iss),
      .cell_addr (walk_cell)
   );

   gepc_mod_acc #(
      .DEPTH (DEPTH)
   ) u_acc (
      .clock     (clock),
      .reset     (reset),
      .iss       (walk_iss),
      .cell_addr (walk_cell),
      .rd_data0  (rd_data0),
      .rd_data1  (rd_data1),
      .wr_en     (wr_en),
      .wr_bank   (wr_bank),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data)
   );

   // The final fetch of the start cell shares the read port once the sweep has ended.
   assign rd_addr = fetch ? start_addr_ff : walk_rd_addr;
   assign rd_en0  = (walk_rd_en && !walk_rd_bank) || (fetch && !moves_ff[0]);
   assign rd_en1  = (walk_rd_en && walk_rd_bank) || (fetch && moves_ff[0]);
   assign wr_en0  = wr_en && !wr_bank;
   assign wr_en1  = wr_en && wr_bank;

   gepc_layer_mem #(
      .DEPTH (DEPTH)
   ) u_bank0 (
      .clock   (clock),
      .wr_en   (wr_en0),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en0),
      .rd_addr (rd_addr),
      .rd_data (rd_data0)
   );

   gepc_layer_mem #(
      .DEPTH (DEPTH)
   ) u_bank1 (
      .clock   (clock),
      .wr_en   (wr_en1),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en1),
      .rd_addr (rd_addr),
      .rd_data (rd_data1)
   );

   // A bank is never read and written in the same cycle.
   a_bank0_no_overlap : assert property (@(posedge clock) disable iff (reset)
      wr_en0 |-> !rd_en0)
      else $error("bank 0 read while being written");

   a_bank1_no_overlap : assert property (@(posedge clock) disable iff (reset)
      wr_en1 |-> !rd_en1)
      else $error("bank 1 read while being written");

   a_ready_only_idle_walker : assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !walk_busy)
      else $error("request taken while the sweep is still running");

   a_count_reduced : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_path_count_ff < PATH_MOD))
      else $error("path count not reduced below the modulus");

   a_bad_start_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_bad_start_ff) |-> (rsp_path_count_ff == '0))
      else $error("bad start reported with a nonzero count");

endmodule

FILE: src/gepc_layer_mem.sv
// One layer store: synchronous memory with one write port and one registered read port.
module gepc_layer_mem
   import gepc_pkg::*;
#(
   parameter int DEPTH = DEF_MAX_ROWS * DEF_MAX_COLS
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [idx_w(DEPTH)-1:0]   wr_addr,
   input  logic [COUNT_W-1:0]        wr_data,
   input  logic                      rd_en,
   input  logic [idx_w(DEPTH)-1:0]   rd_addr,
   output logic [COUNT_W-1:0]        rd_data
);

   logic [COUNT_W-1:0] mem [DEPTH];
   logic [COUNT_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/gepc_cell_walker.sv
// Sequencer that walks every cell of every move layer and issues its four neighbor steps.
module gepc_cell_walker
   import gepc_pkg::*;
#(
   parameter int MAX_ROWS  = DEF_MAX_ROWS,
   parameter int MAX_COLS  = DEF_MAX_COLS,
   parameter int MAX_MOVES = DEF_MAX_MOVES
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [cnt_w(MAX_ROWS)-1:0]           rows,
   input  logic [cnt_w(MAX_COLS)-1:0]           cols,
   input  logic [cnt_w(MAX_MOVES)-1:0]          moves,
   output logic                                 busy,
   output logic                                 done,
   output logic                                 rd_en,
   output logic                                 rd_bank,
   output logic [idx_w(MAX_ROWS*MAX_COLS)-1:0]  rd_addr,
   output issue_type                            iss,
   output logic [idx_w(MAX_ROWS*MAX_COLS)-1:0]  cell_addr
);

   localparam int AW  = idx_w(MAX_ROWS * MAX_COLS);
   localparam int RIW = idx_w(MAX_ROWS);
   localparam int CIW = idx_w(MAX_COLS);
   localparam int RCW = cnt_w(MAX_ROWS);
   localparam int CCW = cnt_w(MAX_COLS);
   localparam int MCW = cnt_w(MAX_MOVES);
   localparam logic [AW-1:0] COL_STEP = AW'(MAX_COLS);

   localparam logic [1:0] W_IDLE = 2'd0;
   localparam logic [1:0] W_RUN  = 2'd1;
   localparam logic [1:0] W_GAP  = 2'd2;

   logic [1:0]     wstate_ff, wstate_in;
   logic [MCW-1:0] layer_ff, layer_in;
   logic [RIW-1:0] row_ff, row_in;
   logic [CIW-1:0] col_ff, col_in;
   logic [1:0]     phase_ff, phase_in;
   logic [AW-1:0]  cell_ff, cell_in;
   logic [AW-1:0]  row_base_ff, row_base_in;
   logic           done_ff, done_in;

   logic           last_row;
   logic           last_col;
   logic           in_grid;
   logic [AW-1:0]  nb_addr;
   logic           running;

   assign running  = (wstate_ff == W_RUN);
   assign last_row = ((RCW'(row_ff) + RCW'(1)) == rows);
   assign last_col = ((CCW'(col_ff) + CCW'(1)) == cols);

   always_comb begin
      in_grid = 1'b0;
      nb_addr = cell_ff;
      case (phase_ff)
         PH_UP: begin
            in_grid = (row_ff != '0);
            nb_addr = cell_ff - COL_STEP;
         end
         PH_RIGHT: begin
            in_grid = !last_col;
            nb_addr = cell_ff + AW'(1);
         end
         PH_DOWN: begin
            in_grid = !last_row;
            nb_addr = cell_ff + COL_STEP;
         end
         PH_LEFT: begin
            in_grid = (col_ff != '0);
            nb_addr = cell_ff - AW'(1);
         end
         default: begin
            in_grid = 1'b0;
            nb_addr = cell_ff;
         end
      endcase
   end

   // The first layer has no previous layer to read, so its reads are skipped and count as zero.
   assign rd_en   = running && in_grid && (layer_ff != '0);
   assign rd_bank = layer_ff[0];
   assign rd_addr = nb_addr;

   always_comb begin
      iss          = '0;
      iss.valid    = running;
      iss.in_grid  = in_grid;
      iss.zero_src = (layer_ff == '0);
      iss.first    = (phase_ff == PH_UP);
      iss.last     = (phase_ff == PH_LEFT);
      iss.rbank    = layer_ff[0];
      iss.wbank    = !layer_ff[0];
   end

   assign cell_addr = cell_ff;
   assign busy      = (wstate_ff != W_IDLE);
   assign done      = done_ff;

   always_comb begin
      wstate_in   = wstate_ff;
      layer_in    = layer_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      phase_in    = phase_ff;
      cell_in     = cell_ff;
      row_base_in = row_base_ff;
      done_in     = 1'b0;
      case (wstate_ff)
         W_IDLE: begin
            if (start) begin
               wstate_in   = W_RUN;
               layer_in    = '0;
               row_in      = '0;
               col_in      = '0;
               phase_in    = PH_UP;
               cell_in     = '0;
               row_base_in = '0;
            end
         end
         W_RUN: begin
            phase_in = phase_ff + 2'd1;
            if (phase_ff == PH_LEFT) begin
               if (last_col) begin
                  col_in = '0;
                  if (last_row) begin
                     row_in      = '0;
                     cell_in     = '0;
                     row_base_in = '0;
                     wstate_in   = W_GAP;
                  end else begin
                     row_in      = row_ff + RIW'(1);
                     row_base_in = row_base_ff + COL_STEP;
                     cell_in     = row_base_ff + COL_STEP;
                  end
               end else begin
                  col_in  = col_ff + CIW'(1);
                  cell_in = cell_ff + AW'(1);
               end
            end
         end
         W_GAP: begin
            // The idle gap state lets the last write of the layer land before the next layer reads.
            if ((layer_ff + MCW'(1)) == moves) begin
               wstate_in = W_IDLE;
               layer_in  = '0;
               done_in   = 1'b1;
            end else begin
               layer_in  = layer_ff + MCW'(1);
               wstate_in = W_RUN;
            end
         end
         default: begin
            wstate_in = W_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wstate_ff   <= W_IDLE;
         layer_ff    <= '0;
         row_ff      <= '0;
         col_ff      <= '0;
         phase_ff    <= PH_UP;
         cell_ff     <= '0;
         row_base_ff <= '0;
         done_ff     <= 1'b0;
      end else begin
         wstate_ff   <= wstate_in;
         layer_ff    <= layer_in;
         row_ff      <= row_in;
         col_ff      <= col_in;
         phase_ff    <= phase_in;
         cell_ff     <= cell_in;
         row_base_ff <= row_base_in;
         done_ff     <= done_in;
      end
   end

endmodule

FILE: src/gepc_mod_acc.sv
// Modular accumulator that sums four neighbor terms per cell and writes the cell of the new layer.
module gepc_mod_acc
   import gepc_pkg::*;
#(
   parameter int DEPTH = DEF_MAX_ROWS * DEF_MAX_COLS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  issue_type                iss,
   input  logic [idx_w(DEPTH)-1:0]  cell_addr,
   input  logic [COUNT_W-1:0]       rd_data0,
   input  logic [COUNT_W-1:0]       rd_data1,
   output logic                     wr_en,
   output logic                     wr_bank,
   output logic [idx_w(DEPTH)-1:0]  wr_addr,
   output logic [COUNT_W-1:0]       wr_data
);

   localparam int AW = idx_w(DEPTH);

   issue_type          iss_ff;
   logic [AW-1:0]      cell_ff;
   logic [COUNT_W-1:0] acc_ff, acc_in;

   logic [COUNT_W-1:0] src;
   logic [COUNT_W-1:0] term;
   logic [COUNT_W:0]   sum;
   logic [COUNT_W:0]   red;

   // Both operands stay below the modulus, so one conditional subtract reduces the sum.
   always_comb begin
      src = iss_ff.rbank ? rd_data1 : rd_data0;
      if (!iss_ff.in_grid) begin
         term = COUNT_W'(1);
      end else if (iss_ff.zero_src) begin
         term = '0;
      end else begin
         term = src;
      end
      sum = {1'b0, (iss_ff.first ? '0 : acc_ff)} + {1'b0, term};
      red = (sum >= {1'b0, PATH_MOD}) ? (sum - {1'b0, PATH_MOD}) : sum;
      acc_in = iss_ff.valid ? red[COUNT_W-1:0] : acc_ff;
   end

   assign wr_en   = iss_ff.valid && iss_ff.last;
   assign wr_bank = iss_ff.wbank;
   assign wr_addr = cell_ff;
   assign wr_data = red[COUNT_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         iss_ff <= '0;
      end else begin
         iss_ff <= iss;
      end
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_addr;
      acc_ff  <= acc_in;
   end

endmodule

FILE: test/tb_grid_exit_path_counter_core.sv
// Testbench for the grid exit path counter core: directed and random queries checked against a predictor.
`timescale 1ns / 1ps

module tb_grid_exit_path_counter_core;
   import gepc_pkg::*;

   localparam int GRID_CELLS     = DEF_MAX_ROWS * DEF_MAX_COLS;
   localparam int WATCHDOG_LIMIT = 250000;

   typedef struct {
      logic [COUNT_W-1:0] path_count;
      logic               bad_start;
   } walk_result_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [POS_W-1:0]     req_start_row;
   logic [POS_W-1:0]     req_start_col;
   logic [MOVE_W-1:0]    req_move_limit;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [COUNT_W-1:0]   rsp_path_count;
   logic                 rsp_bad_start;
   logic                 csr_write;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_wdata;

   // Grid size as last written, before any clamping.
   logic [CFG_W-1:0] grid_rows_cfg;
   logic [CFG_W-1:0] grid_cols_cfg;

   int unsigned     walks_prev [GRID_CELLS];
   int unsigned     walks_next [GRID_CELLS];
   walk_result_type expected_counts [$];

   int mismatch_count = 0;
   int stall_cycles   = 0;
   int rsp_hold       = 0;
   bit quiet_mode     = 1'b0;

   grid_exit_path_counter_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_start_row  (req_start_row),
      .req_start_col  (req_start_col),
      .req_move_limit (req_move_limit),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_path_count (rsp_path_count),
      .rsp_bad_start  (rsp_bad_start),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #1 clock = ~clock;

   // Mostly short gaps, now and then a long one.
   function automatic int idle_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 50) return 0;
      if (pick < 85) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   // Backward layer sweep: a cell of the new layer sums its four neighbors of the
   // previous layer, and each step off the grid adds one exiting walk.
   function automatic logic [COUNT_W-1:0] count_exit_walks(input logic [POS_W-1:0] row,
         input logic [POS_W-1:0] col, input logic [MOVE_W-1:0] moves,
         output logic off_grid);
      int rows;
      int cols;
      int steps;
      longint unsigned acc;
      rows  = (grid_rows_cfg > DEF_MAX_ROWS) ? DEF_MAX_ROWS : int'(grid_rows_cfg);
      cols  = (grid_cols_cfg > DEF_MAX_COLS) ? DEF_MAX_COLS : int'(grid_cols_cfg);
      steps = (moves > DEF_MAX_MOVES) ? DEF_MAX_MOVES : int'(moves);
      off_grid = (int'(row) >= rows) || (int'(col) >= cols);
      if (off_grid) return '0;
      foreach (walks_prev[n]) walks_prev[n] = 0;
      for (int t = 0; t < steps; t++) begin
         for (int i = 0; i < rows; i++) begin
            for (int j = 0; j < cols; j++) begin
               acc = 0;
               acc += (i == 0) ? 1 : walks_prev[(i - 1) * DEF_MAX_COLS + j];
               acc += (j == cols - 1) ? 1 : walks_prev[i * DEF_MAX_COLS + j + 1];
               acc += (i == rows - 1) ? 1 : walks_prev[(i + 1) * DEF_MAX_COLS + j];
               acc += (j == 0) ? 1 : walks_prev[i * DEF_MAX_COLS + j - 1];
               walks_next[i * DEF_MAX_COLS + j] = 32'(acc % PATH_MOD);
            end
         end
         walks_prev = walks_next;
      end
      return COUNT_W'(walks_prev[int'(row) * DEF_MAX_COLS + int'(col)]);
   endfunction

   task automatic send_query(input logic [POS_W-1:0] row, input logic [POS_W-1:0] col,
                             input logic [MOVE_W-1:0] moves);
      walk_result_type want;
      logic off_grid;
      int gap;
      gap = quiet_mode ? 0 : idle_length();
      want.path_count = count_exit_walks(row, col, moves, off_grid);
      want.bad_start  = off_grid;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_start_row  <= row;
      req_start_col  <= col;
      req_move_limit <= moves;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_counts.push_back(want);
   endtask

   // Drops the request and waits until every expected count has come back.
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_counts.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] index, input logic [CFG_W-1:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      if (index == CSR_GRID_ROWS) grid_rows_cfg = value;
      else grid_cols_cfg = value;
   endtask

   task automatic set_grid(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols);
      write_csr(CSR_GRID_ROWS, rows);
      write_csr(CSR_GRID_COLS, cols);
   endtask

   // The reset grid is a single cell, so every move leaves it four ways.
   task automatic test_reset_grid();
      send_query(0, 0, 0);
      send_query(0, 0, 1);
      send_query(0, 1, 5);
      send_query(63, 63, 127);
      wait_idle();
   endtask

   task automatic test_empty_grid();
      set_grid(0, 5);
      send_query(0, 0, 3);
      wait_idle();
      set_grid(3, 0);
      send_query(0, 0, 3);
      wait_idle();
   endtask

   task automatic test_full_grid();
      set_grid(64, 64);
      send_query(63, 63, 4);
      send_query(0, 0, 1);
      send_query(32, 32, 4);
      send_query(0, 63, 0);
      send_query(63, 0, 2);
      wait_idle();
   endtask

   // Row count beyond the largest grid is treated as the largest grid.
   task automatic test_clamped_grid();
      set_grid(127, 2);
      send_query(63, 1, 64);
      send_query(40, 0, 127);
      wait_idle();
   endtask

   // Long walks drive the counts well past the modulus; a zero move limit and an off-grid start are mixed in.
   task automatic test_long_walks();
      set_grid(4, 5);
      send_query(1, 2, 64);
      send_query(3, 4, 127);
      send_query(0, 0, 65);
      send_query(2, 2, 63);
      send_query(3, 0, 0);
      send_query(4, 0, 9);
      wait_idle();
   endtask

   task automatic test_random_queries();
      int sent;
      int batch;
      int kind;
      int pick;
      int eff_rows;
      int eff_cols;
      logic [CFG_W-1:0] rows;
      logic [CFG_W-1:0] cols;
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
      logic [MOVE_W-1:0] moves;
      sent = 0;
      while (sent < 80) begin
         kind = $urandom_range(0, 9);
         quiet_mode = ($urandom_range(0, 3) == 0);
         if (kind == 0) begin
            // Large grids stay cheap only with very short walks.
            rows  = CFG_W'($urandom_range(1, 127));
            cols  = CFG_W'($urandom_range(1, 127));
            batch = 4;
         end else if (kind == 1) begin
            rows  = ($urandom_range(0, 1) != 0) ? '0 : CFG_W'($urandom_range(1, 8));
            cols  = (rows == '0) ? CFG_W'($urandom_range(0, 8)) : '0;
            batch = 3;
         end else begin
            rows  = CFG_W'($urandom_range(1, 8));
            cols  = CFG_W'($urandom_range(1, 8));
            batch = $urandom_range(10, 15);
         end
         set_grid(rows, cols);
         eff_rows = (rows > DEF_MAX_ROWS) ? DEF_MAX_ROWS : int'(rows);
         eff_cols = (cols > DEF_MAX_COLS) ? DEF_MAX_COLS : int'(cols);
         repeat (batch) begin
            if (eff_rows > 0 && eff_cols > 0 && $urandom_range(0, 99) < 85) begin
               row = POS_W'($urandom_range(0, eff_rows - 1));
               col = POS_W'($urandom_range(0, eff_cols - 1));
            end else begin
               row = POS_W'($urandom_range(0, 63));
               col = POS_W'($urandom_range(0, 63));
            end
            pick = $urandom_range(0, 99);
            if (kind == 0) moves = MOVE_W'($urandom_range(0, 2));
            else if (pick < 10) moves = MOVE_W'($urandom_range(65, 127));
            else if (pick < 25) moves = MOVE_W'($urandom_range(0, 3));
            else moves = MOVE_W'($urandom_range(1, 48));
            send_query(row, col, moves);
         end
         sent += batch;
         wait_idle();
      end
      quiet_mode = 1'b0;
   endtask

   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold  <= rsp_hold - 1;
      end else if (!quiet_mode && $urandom_range(0, 3) == 0) begin
         rsp_ready <= 1'b0;
         rsp_hold  <= idle_length();
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      walk_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_counts.size() == 0) begin
            $display("%0t: unexpected result transfer, path_count %0d bad_start %0b",
                     $time, rsp_path_count, rsp_bad_start);
            mismatch_count++;
         end else begin
            want = expected_counts.pop_front();
            if (rsp_path_count !== want.path_count) begin
               $display("%0t: path_count expected %0d actual %0d",
                        $time, want.path_count, rsp_path_count);
               mismatch_count++;
            end
            if (rsp_bad_start !== want.bad_start) begin
               $display("%0t: bad_start expected %0b actual %0b",
                        $time, want.bad_start, rsp_bad_start);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, stall_cycles);
         $display("Verification failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_start_row  = '0;
      req_start_col  = '0;
      req_move_limit = '0;
      rsp_ready      = 1'b0;
      csr_write      = 1'b0;
      csr_index      = CSR_GRID_ROWS;
      csr_wdata      = '0;
      grid_rows_cfg  = 7'd1;
      grid_cols_cfg  = 7'd1;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      test_reset_grid();
      test_empty_grid();
      test_full_grid();
      test_clamped_grid();
      test_long_walks();
      test_random_queries();

      wait_idle();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

FILE: grid_exit_path_counter_core.f
src/gepc_pkg.sv
src/gepc_layer_mem.sv
src/gepc_cell_walker.sv
src/gepc_mod_acc.sv
src/grid_exit_path_counter_core.sv
test/tb_grid_exit_path_counter_core.sv
